// ===== rtl/rau_pkg.sv =====
// rau_pkg: shared constants, opcode codes, controller states and the
// command and status structs between controller and datapath
// no dependencies
package rau_pkg;

    // word width of all fraction parts
    localparam int W        = 32;
    localparam int CNT_W    = $clog2(W);
    localparam int IN_BITS  = 136;
    localparam int OUT_BITS = 72;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_LT  = 4'd4,
        OP_LE  = 4'd5,
        OP_GT  = 4'd6,
        OP_GE  = 4'd7,
        OP_EQ  = 4'd8,
        OP_NE  = 4'd9,
        OP_INC = 4'd10,
        OP_DEC = 4'd11,
        OP_RED = 4'd12
    } t_opcode;

    // which cross product the shared multiplier forms
    typedef enum logic [1:0] {
        PROD_LN_RD = 2'd0,
        PROD_LD_RN = 2'd1,
        PROD_LD_RD = 2'd2,
        PROD_LN_RN = 2'd3
    } t_mul_sel;

    // which job the shared divider runs
    typedef enum logic [1:0] {
        DIV_EUC = 2'd0,
        DIV_QN  = 2'd1,
        DIV_QD  = 2'd2
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_EUC_CHK,
        S_EUC_RUN,
        S_QN_RUN,
        S_QD_GO,
        S_QD_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_start;
        logic     div_cap;
        t_div_sel div_sel;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic is_reduce;
        logic d_zero;
        logic n_zero;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// rational_arithmetic_unit: fraction add, sub, mul, div, compare,
// inc, dec and reduce. Input words arrive on the slave stream, each
// holding an opcode and two fractions; one result word per input leaves
// on the master stream. Accepts a word only when idle.
// Arithmetic, compare, inc and dec pass through the multiply states
// S_MUL_A to S_MUL_D on the one shared 32x32 multiplier and then the
// select state S_DONE, which loads the output register; a new word is
// taken only after that load, once the controller is back in idle.
// Reduce runs Euclid on the shared one-bit-per-cycle divider: one
// remainder division per Euclid step, then the numerator quotient and
// the denominator quotient, each on the same divider.
// The result sits in an output register, so the next word is accepted
// while it waits for the receiver; a stalled receiver holds the result
// and the finished next result waits in the controller until the
// register frees. Synchronous active-low reset empties the output
// register and returns the controller to idle.
// depends on rau_pkg, rau_ctrl, rau_dp, rau_div
module rational_arithmetic_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // opcode[3:0], left_num[35:4], left_den[67:36], right_num[99:68],
    // right_den[131:100], zero pad[135:132]
    input  logic [rau_pkg::IN_BITS-1:0]  i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // result_num[31:0], result_den[63:32], truth[64], den_error[65],
    // zero pad[71:66]
    output logic [rau_pkg::OUT_BITS-1:0] o_m_tdata
);
    import rau_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic and output word
    rau_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_tdata),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

// ===== rtl/rau_div.sv =====
// rau_div: unsigned restoring divider, one quotient bit per cycle
// depends on rau_pkg
module rau_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [rau_pkg::W-1:0] i_dividend,
    input  logic [rau_pkg::W-1:0] i_divisor,
    output logic [rau_pkg::W-1:0] o_quo,
    output logic [rau_pkg::W-1:0] o_rem,
    output logic                 o_done
);
    import rau_pkg::*;

    logic [W-1:0]     r_rem, r_quo, r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [W:0]       shifted, diff;

    // trial subtract of the divisor from the shifted partial remainder
    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    // control: busy flag, bit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

// ===== rtl/rau_ctrl.sv =====
// rau_ctrl: sequencing state machine for the fraction unit
// depends on rau_pkg
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd
);
    import rau_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.mul_sel   = PROD_LN_RD;
        o_cmd.div_sel   = DIV_EUC;
        o_in_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = PROD_LN_RD;
                n_state       = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = PROD_LD_RN;
                n_state       = S_MUL_C;
            end
            S_MUL_C: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = PROD_LD_RD;
                n_state       = S_MUL_D;
            end
            S_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = PROD_LN_RN;
                n_state       = i_stat.is_reduce ? S_EUC_CHK : S_DONE;
            end
            S_EUC_CHK: begin
                // euclid ends when the divisor reaches zero
                if (!i_stat.d_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_EUC;
                    n_state         = S_EUC_RUN;
                end else if (i_stat.n_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_QN;
                    n_state         = S_QN_RUN;
                end
            end
            S_EUC_RUN: begin
                o_cmd.div_sel = DIV_EUC;
                if (i_stat.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = S_EUC_CHK;
                end
            end
            S_QN_RUN: begin
                if (i_stat.div_done) begin
                    o_cmd.div_cap   = 1'b1;
                    o_cmd.div_sel   = DIV_QN;
                    n_state         = S_QD_GO;
                end
            end
            S_QD_GO: begin
                // denominator quotient starts on its own operands
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_QD;
                n_state         = S_QD_RUN;
            end
            S_QD_RUN: begin
                o_cmd.div_sel = DIV_QD;
                if (i_stat.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rau_dp.sv =====
// rau_dp: operand registers, shared multiplier, euclid registers,
// shared divider and the output word register
// depends on rau_pkg and rau_div
module rau_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rau_pkg::IN_BITS-1:0] i_in_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [rau_pkg::OUT_BITS-1:0] o_out_data,
    input  rau_pkg::t_cmd               i_cmd,
    output rau_pkg::t_stat              o_stat
);
    import rau_pkg::*;

    t_opcode      r_op;
    logic [W-1:0] r_ln, r_ld, r_rn, r_rd;
    logic [W-1:0] r_a, r_b, r_c, r_d;
    logic [W-1:0] r_n, r_dv, r_qn, r_qd;
    logic [W-1:0] mul_x, mul_y, prod;
    logic [W-1:0] div_a, div_b, quo, rem;
    logic         div_done;
    logic         r_out_valid;
    logic [W-1:0] r_res_num, r_res_den;
    logic         r_truth, r_err;
    logic [W-1:0] n_res_num, n_res_den;
    logic         n_truth, n_err, arith;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        mag = x[W-1] ? (W'(0) - x) : x;
    endfunction

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_opcode'(i_in_data[3:0]);
            r_ln <= i_in_data[4 +: W];
            r_ld <= i_in_data[4 + W +: W];
            r_rn <= i_in_data[4 + 2*W +: W];
            r_rd <= i_in_data[4 + 3*W +: W];
        end
    end

    // shared multiplier, low word of the product
    always_comb begin
        case (i_cmd.mul_sel)
            PROD_LN_RD: begin mul_x = r_ln; mul_y = r_rd; end
            PROD_LD_RN: begin mul_x = r_ld; mul_y = r_rn; end
            PROD_LD_RD: begin mul_x = r_ld; mul_y = r_rd; end
            default:    begin mul_x = r_ln; mul_y = r_rn; end
        endcase
    end

    assign prod = mul_x * mul_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                PROD_LN_RD: r_a <= prod;
                PROD_LD_RN: r_b <= prod;
                PROD_LD_RD: r_c <= prod;
                default:    r_d <= prod;
            endcase
        end
    end

    // divider operands on magnitudes
    always_comb begin
        case (i_cmd.div_sel)
            DIV_EUC: begin div_a = mag(r_n);  div_b = mag(r_dv); end
            DIV_QN:  begin div_a = mag(r_ln); div_b = mag(r_n);  end
            default: begin div_a = mag(r_ld); div_b = mag(r_n);  end
        endcase
    end

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_quo      (quo),
        .o_rem      (rem),
        .o_done     (div_done)
    );

    // euclid pair and quotient capture; remainder sign follows the dividend
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n  <= i_in_data[4 +: W];
            r_dv <= i_in_data[4 + W +: W];
        end else if (i_cmd.div_cap) begin
            case (i_cmd.div_sel)
                DIV_EUC: begin
                    r_n  <= r_dv;
                    r_dv <= r_n[W-1] ? (W'(0) - rem) : rem;
                end
                DIV_QN: begin
                    r_qn <= (r_ln[W-1] ^ r_n[W-1]) ? (W'(0) - quo) : quo;
                end
                default: begin
                    r_qd <= (r_ld[W-1] ^ r_n[W-1]) ? (W'(0) - quo) : quo;
                end
            endcase
        end
    end

    // result selection
    always_comb begin
        n_res_num = '0;
        n_res_den = '0;
        n_truth   = 1'b0;
        n_err     = 1'b0;
        arith     = 1'b1;
        case (r_op)
            OP_ADD: begin n_res_num = r_a + r_b; n_res_den = r_c; end
            OP_SUB: begin n_res_num = r_a - r_b; n_res_den = r_c; end
            OP_MUL: begin n_res_num = r_d;       n_res_den = r_c; end
            OP_DIV: begin n_res_num = r_a;       n_res_den = r_b; end
            OP_LT:  begin n_truth = $signed(r_a) <  $signed(r_b); arith = 1'b0; end
            OP_LE:  begin n_truth = $signed(r_a) <= $signed(r_b); arith = 1'b0; end
            OP_GT:  begin n_truth = $signed(r_a) >  $signed(r_b); arith = 1'b0; end
            OP_GE:  begin n_truth = $signed(r_a) >= $signed(r_b); arith = 1'b0; end
            OP_EQ:  begin n_truth = (r_a == r_b); arith = 1'b0; end
            OP_NE:  begin n_truth = (r_a != r_b); arith = 1'b0; end
            OP_INC: begin n_res_num = r_ln + r_ld; n_res_den = r_ld; end
            OP_DEC: begin n_res_num = r_ln - r_ld; n_res_den = r_ld; end
            OP_RED: begin
                // zero gcd: both parts zero, flagged as an error
                if (r_n != '0) begin
                    n_res_num = r_qn;
                    n_res_den = r_qd;
                end
            end
            default: begin
                arith = 1'b0;
            end
        endcase
        if (arith && n_res_den == '0) begin
            n_err = 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res_num <= n_res_num;
            r_res_den <= n_res_den;
            r_truth   <= n_truth;
            r_err     <= n_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_BITS - 2*W - 2){1'b0}}, r_err, r_truth, r_res_den, r_res_num};

    // status to the controller
    assign o_stat.is_reduce = (r_op == OP_RED);
    assign o_stat.d_zero    = (r_dv == '0);
    assign o_stat.n_zero    = (r_n == '0);
    assign o_stat.div_done  = div_done;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule
